// ===== src/bha_pkg.sv =====
`default_nettype none

package bha_pkg;

    localparam int HANDLE_W        = 16;
    localparam int DEF_NUM_HANDLES = 65536;
    localparam int DEF_WORD_BITS   = 64;

    localparam logic FUNC_ALLOC   = 1'b0;
    localparam logic FUNC_RELEASE = 1'b1;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_EMPTY = 1'b1;

endpackage

`default_nettype wire

// ===== src/bitmap_handle_allocator_core.sv =====
// Bitmap handle allocator.
// A word on the slave stream is one request: s_axis_tuser selects allocate (0) or
// release (1), s_axis_tdata carries the handle to release. Every request gives exactly
// one word on the master stream: m_axis_tdata holds the allocated or echoed handle and
// m_axis_tuser is the status (1 when no handle is free).
// The map lives in one synchronous memory of NUM_HANDLES / WORD_BITS words, rounded
// up, and is updated by read-modify-write, one request at a time. An allocation reads
// the word the scan pointer holds (state SCAN), moves to the next word for every fully
// allocated word it skips, and forms the handle (state FIN); the scan pointer only moves
// back on a release, so skips are rare. Once the map is known to be empty an allocation
// answers without a memory read. A release divides the handle by a constant multiply
// (state DIV), reads the word that holds it (state IDX) and sets its bit (state SET).
// The next request is taken in the same cycle as the result appears.
// After reset every handle is free. Words at or above a high-water mark have never been
// written and read as all free, so no clearing pass is needed and requests are taken
// straight after reset.
// The result waits in an output register while the receiver stalls; a new request
// is accepted meanwhile, and its result is held back until the register is free.
`default_nettype none

module bitmap_handle_allocator_core #(
    parameter int NUM_HANDLES = bha_pkg::DEF_NUM_HANDLES,
    parameter int WORD_BITS   = bha_pkg::DEF_WORD_BITS
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         s_axis_tvalid,
    output logic                              s_axis_tready,
    input  wire logic [bha_pkg::HANDLE_W-1:0] s_axis_tdata,   // handle_in
    input  wire logic                         s_axis_tuser,   // func
    output logic                              m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    output logic [bha_pkg::HANDLE_W-1:0]      m_axis_tdata,   // handle_out
    output logic                              m_axis_tuser    // status
);

    import bha_pkg::*;

    localparam int NUM_WORDS = (NUM_HANDLES + WORD_BITS - 1) / WORD_BITS;
    localparam int CNT_W     = $clog2(NUM_WORDS + 1);
    localparam int ADDR_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int FULL_W    = CNT_W + BIT_W + 1;
    localparam int LAST_BITS = NUM_HANDLES - (NUM_WORDS - 1) * WORD_BITS;

    localparam int DIV_SHIFT = HANDLE_W + BIT_W;
    localparam int DIV_MUL   = ((2 ** DIV_SHIFT) + WORD_BITS - 1) / WORD_BITS;
    localparam int MUL_W     = $clog2(DIV_MUL + 1);
    localparam int PROD_W    = HANDLE_W + MUL_W;

    localparam logic [CNT_W-1:0]     WORDS_END = CNT_W'(NUM_WORDS);
    localparam logic [CNT_W-1:0]     LAST_IDX  = CNT_W'(NUM_WORDS - 1);
    localparam logic [WORD_BITS-1:0] FULL_MASK = {WORD_BITS{1'b1}};
    localparam logic [WORD_BITS-1:0] LAST_MASK = FULL_MASK >> (WORD_BITS - LAST_BITS);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_FIN  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_IDX  = 3'd4;
    localparam logic [2:0] S_SET  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0]           r_state, n_state;
    logic [CNT_W-1:0]     r_hint, n_hint;
    logic [CNT_W-1:0]     r_hwm, n_hwm;
    logic [CNT_W-1:0]     r_addr, n_addr;
    logic [HANDLE_W-1:0]  r_h, n_h;
    logic [HANDLE_W-1:0]  r_q, n_q;
    logic [BIT_W-1:0]     r_bit, n_bit;
    logic [HANDLE_W-1:0]  r_res_h, n_res_h;
    logic                 r_res_st, n_res_st;
    logic                 r_ovalid, n_ovalid;
    logic [HANDLE_W-1:0]  r_odata, n_odata;
    logic                 r_ouser, n_ouser;
    logic [WORD_BITS-1:0] r_rdata;

    logic [WORD_BITS-1:0] map_mem [NUM_WORDS];

    logic                 mem_rd_en;
    logic [ADDR_W-1:0]    mem_rd_addr;
    logic                 mem_wr_en;
    logic [ADDR_W-1:0]    mem_wr_addr;
    logic [WORD_BITS-1:0] mem_wr_data;

    logic [WORD_BITS-1:0] scan_word;
    logic [WORD_BITS-1:0] scan_clr;
    logic                 scan_found;
    logic [BIT_W-1:0]     scan_idx;
    logic [CNT_W-1:0]     scan_next;
    logic [PROD_W-1:0]    div_prod;
    logic [HANDLE_W-1:0]  rem_full;
    logic [CNT_W-1:0]     rel_addr;
    logic [FULL_W-1:0]    alloc_handle;

    always_comb begin
        if (r_addr >= r_hwm) begin
            scan_word = (r_addr == LAST_IDX) ? LAST_MASK : FULL_MASK;
        end else begin
            scan_word = r_rdata;
        end
    end

    bha_lowest_set #(
        .WORD_BITS (WORD_BITS)
    ) u_lowest_set (
        .i_word  (scan_word),
        .o_found (scan_found),
        .o_idx   (scan_idx)
    );

    assign scan_clr     = scan_word & ~(WORD_BITS'(1) << scan_idx);
    assign scan_next    = r_addr + CNT_W'(1);
    assign div_prod     = PROD_W'(r_h) * PROD_W'(DIV_MUL);
    assign rem_full     = r_h - HANDLE_W'(r_q * HANDLE_W'(WORD_BITS));
    assign rel_addr     = CNT_W'(r_q);
    assign alloc_handle = FULL_W'(r_addr) * FULL_W'(WORD_BITS) + FULL_W'(r_bit);

    always_comb begin
        n_state     = r_state;
        n_hint      = r_hint;
        n_hwm       = r_hwm;
        n_addr      = r_addr;
        n_h         = r_h;
        n_q         = r_q;
        n_bit       = r_bit;
        n_res_h     = r_res_h;
        n_res_st    = r_res_st;
        n_ovalid    = r_ovalid & ~m_axis_tready;
        n_odata     = r_odata;
        n_ouser     = r_ouser;
        mem_rd_en   = 1'b0;
        mem_rd_addr = r_hint[ADDR_W-1:0];
        mem_wr_en   = 1'b0;
        mem_wr_addr = r_addr[ADDR_W-1:0];
        mem_wr_data = scan_clr;

        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_h = s_axis_tdata;
                    if (s_axis_tuser == FUNC_ALLOC) begin
                        if (r_hint == WORDS_END) begin
                            n_res_h  = '0;
                            n_res_st = STATUS_EMPTY;
                            n_state  = S_OUT;
                        end else begin
                            mem_rd_en = 1'b1;
                            n_addr    = r_hint;
                            n_state   = S_SCAN;
                        end
                    end else begin
                        n_state = S_DIV;
                    end
                end
            end
            S_SCAN: begin
                if (scan_found) begin
                    mem_wr_en = 1'b1;
                    n_bit     = scan_idx;
                    if (r_addr >= r_hwm) begin
                        n_hwm = scan_next;
                    end
                    n_hint  = (scan_clr == '0) ? scan_next : r_addr;
                    n_state = S_FIN;
                end else begin
                    n_hint = scan_next;
                    if (scan_next == WORDS_END) begin
                        n_res_h  = '0;
                        n_res_st = STATUS_EMPTY;
                        n_state  = S_OUT;
                    end else begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = scan_next[ADDR_W-1:0];
                        n_addr      = scan_next;
                    end
                end
            end
            S_FIN: begin
                n_res_h  = HANDLE_W'(alloc_handle);
                n_res_st = STATUS_OK;
                n_state  = S_OUT;
            end
            S_DIV: begin
                n_q     = HANDLE_W'(div_prod >> DIV_SHIFT);
                n_state = S_IDX;
            end
            S_IDX: begin
                n_bit = rem_full[BIT_W-1:0];
                if (32'(r_h) >= NUM_HANDLES) begin
                    n_res_h  = r_h;
                    n_res_st = STATUS_OK;
                    n_state  = S_OUT;
                end else begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = rel_addr[ADDR_W-1:0];
                    n_addr      = rel_addr;
                    n_state     = S_SET;
                end
            end
            S_SET: begin
                if (r_addr < r_hwm) begin
                    mem_wr_en   = 1'b1;
                    mem_wr_data = r_rdata | (WORD_BITS'(1) << r_bit);
                    if (r_addr < r_hint) begin
                        n_hint = r_addr;
                    end
                end
                n_res_h  = r_h;
                n_res_st = STATUS_OK;
                n_state  = S_OUT;
            end
            S_OUT: begin
                if (!r_ovalid || m_axis_tready) begin
                    n_ovalid = 1'b1;
                    n_odata  = r_res_h;
                    n_ouser  = r_res_st;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_wr_en) begin
            map_mem[mem_wr_addr] <= mem_wr_data;
        end
        if (mem_rd_en) begin
            r_rdata <= map_mem[mem_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_hint   <= '0;
            r_hwm    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_hint   <= n_hint;
            r_hwm    <= n_hwm;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr   <= n_addr;
        r_h      <= n_h;
        r_q      <= n_q;
        r_bit    <= n_bit;
        r_res_h  <= n_res_h;
        r_res_st <= n_res_st;
        r_odata  <= n_odata;
        r_ouser  <= n_ouser;
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ouser;

`ifndef NO_ASSERTIONS
    // Every word below the scan pointer is empty, so it never passes the high-water mark.
    a_hint_below_hwm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hint <= r_hwm)
        else $error("scan pointer above high-water mark");

    a_hwm_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hwm <= WORDS_END)
        else $error("high-water mark beyond the map");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_addr <= r_hwm && r_addr < WORDS_END))
        else $error("scan address outside written region");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == STATUS_EMPTY) |-> (m_axis_tdata == '0))
        else $error("exhaustion result carries a handle");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request accepted while another is in progress");
`endif

endmodule

`default_nettype wire

// ===== src/bha_lowest_set.sv =====
`default_nettype none

module bha_lowest_set #(
    parameter int WORD_BITS = bha_pkg::DEF_WORD_BITS
) (
    input  wire logic [WORD_BITS-1:0]         i_word,
    output logic                              o_found,
    output logic [$clog2(WORD_BITS)-1:0]      o_idx
);

    localparam int BIT_W = $clog2(WORD_BITS);

    always_comb begin
        o_found = |i_word;
        o_idx   = '0;
        for (int k = WORD_BITS - 1; k >= 0; k--) begin
            if (i_word[k]) begin
                o_idx = BIT_W'(k);
            end
        end
    end

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bha_pkg::*;

    localparam int NUM_HANDLES = DEF_NUM_HANDLES;
    localparam int WORD_BITS   = DEF_WORD_BITS;
    localparam int NUM_WORDS   = (NUM_HANDLES + WORD_BITS - 1) / WORD_BITS;
    localparam logic [63:0] WORD_MASK = {64{1'b1}} >> (64 - WORD_BITS);

    typedef struct packed {
        logic                func;
        logic [HANDLE_W-1:0] handle;
        logic [7:0]          gap;
        logic                drain;
        logic                quiet;
    } t_request;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic                status;
    } t_reply;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic [HANDLE_W-1:0] s_axis_tdata  = '0;
    logic                s_axis_tuser  = 1'b0;
    logic                m_axis_tready = 1'b0;
    wire logic                s_axis_tready;
    wire logic                m_axis_tvalid;
    wire logic [HANDLE_W-1:0] m_axis_tdata;
    wire logic                m_axis_tuser;

    t_request    pending_reqs[$];
    t_reply      due_replies[$];
    logic [63:0] free_words[NUM_WORDS];
    int          scan_from;

    t_request    cur_req     = '0;
    bit          req_taken   = 1'b0;
    int unsigned gap_left    = 0;
    logic        bus_quiet   = 1'b0;
    int unsigned stall_left  = 0;
    int unsigned hold_count  = 0;
    bit          hold_done   = 1'b0;
    logic        hold_on     = 1'b0;
    int unsigned replies_seen = 0;
    int unsigned error_count  = 0;

    bitmap_handle_allocator_core #(
        .NUM_HANDLES(NUM_HANDLES),
        .WORD_BITS  (WORD_BITS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),   // handle_in
        .s_axis_tuser (s_axis_tuser),   // func
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),   // handle_out
        .m_axis_tuser (m_axis_tuser)    // status
    );

    always #1 i_clk = ~i_clk;

    function automatic void fill_free_map();
        int i;
        int left;
        for (i = 0; i < NUM_WORDS; i++) begin
            left = NUM_HANDLES - i * WORD_BITS;
            free_words[i] = (left >= WORD_BITS) ? WORD_MASK : ((64'd1 << left) - 64'd1);
        end
        scan_from = 0;
    endfunction

    function automatic void predict_reply(t_request rq);
        t_reply rp;
        int     i;
        int     b;
        int     wi;
        int     full;
        bit     found;
        rp.handle = '0;
        rp.status = STATUS_EMPTY;
        found     = 1'b0;
        if (rq.func == FUNC_ALLOC) begin
            i = scan_from;
            while (!found && i < NUM_WORDS) begin
                if (free_words[i] != 64'd0) begin
                    b = 0;
                    while (!free_words[i][b]) b++;
                    free_words[i][b] = 1'b0;
                    full      = i * WORD_BITS + b;
                    rp.handle = full[HANDLE_W-1:0];
                    rp.status = STATUS_OK;
                    found     = 1'b1;
                end else begin
                    i++;
                end
            end
            scan_from = i;
        end else begin
            if (rq.handle < NUM_HANDLES) begin
                wi = rq.handle / WORD_BITS;
                free_words[wi][rq.handle % WORD_BITS] = 1'b1;
                if (wi < scan_from) scan_from = wi;
            end
            rp.handle = rq.handle;
            rp.status = STATUS_OK;
        end
        due_replies.push_back(rp);
    endfunction

    function automatic logic [7:0] pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 8'd0;
        if (r < 90) return 8'($urandom_range(1, 3));
        if (r < 98) return 8'($urandom_range(4, 12));
        return 8'($urandom_range(20, 60));
    endfunction

    function automatic void queue_req(logic func, logic [HANDLE_W-1:0] handle,
                                      logic [7:0] gap, logic drain, logic quiet);
        t_request rq;
        rq.func   = func;
        rq.handle = handle;
        rq.gap    = gap;
        rq.drain  = drain;
        rq.quiet  = quiet;
        pending_reqs.push_back(rq);
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            predict_reply(cur_req);
            req_taken = 1'b1;
        end
    end

    always @(negedge i_clk) begin : drive_request
        logic offer;
        offer = s_axis_tvalid && !req_taken;
        if (req_taken && pending_reqs.size() > 0) gap_left = 32'(pending_reqs[0].gap);
        req_taken = 1'b0;
        if (i_rst_n && !offer) begin
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending_reqs.size() > 0 &&
                         !(pending_reqs[0].drain && due_replies.size() > 0)) begin
                cur_req = pending_reqs.pop_front();
                offer   = 1'b1;
            end
        end
        s_axis_tvalid <= offer;
        s_axis_tdata  <= cur_req.handle;
        s_axis_tuser  <= cur_req.func;
        bus_quiet     <= cur_req.quiet;
    end

    always @(negedge i_clk) begin : drive_ready
        logic rdy;
        if (hold_on) begin
            rdy = 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            rdy = 1'b0;
        end else begin
            rdy = 1'b1;
            if (!bus_quiet && $urandom_range(0, 2) == 0) stall_left = 32'(pick_gap());
        end
        m_axis_tready <= rdy;
    end

    always @(negedge i_clk) begin
        if (hold_count > 0) begin
            hold_count--;
        end else if (!hold_done && replies_seen >= 300) begin
            hold_count = 400;
            hold_done  = 1'b1;
        end
        hold_on <= (hold_count > 0);
    end

    always @(posedge i_clk) begin : check_reply
        t_reply want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            replies_seen++;
            if (due_replies.size() == 0) begin
                if (error_count < 10)
                    $display("Unexpected word: handle %h status %b", m_axis_tdata, m_axis_tuser);
                error_count++;
            end else begin
                want = due_replies.pop_front();
                if (m_axis_tdata !== want.handle || m_axis_tuser !== want.status) begin
                    if (error_count < 10)
                        $display("Mismatch: handle %h status %b, expected handle %h status %b",
                                 m_axis_tdata, m_axis_tuser, want.handle, want.status);
                    error_count++;
                end
            end
        end
    end

    initial begin
        #8000000;
        $display("FAILURE");
        $finish;
    end

    initial begin : run_test
        int          n;
        int unsigned r;
        int unsigned outstanding;
        logic        quiet;

        fill_free_map();

        queue_req(FUNC_ALLOC,   16'h0000, pick_gap(), 1'b0, 1'b0);
        queue_req(FUNC_ALLOC,   16'hFFFF, pick_gap(), 1'b0, 1'b0);
        queue_req(FUNC_ALLOC,   16'h5555, pick_gap(), 1'b0, 1'b0);
        queue_req(FUNC_RELEASE, 16'h0001, pick_gap(), 1'b0, 1'b0);
        queue_req(FUNC_RELEASE, 16'h0001, pick_gap(), 1'b0, 1'b0);
        queue_req(FUNC_ALLOC,   16'hAAAA, pick_gap(), 1'b0, 1'b0);
        queue_req(FUNC_RELEASE, 16'hFFFF, pick_gap(), 1'b0, 1'b0);
        queue_req(FUNC_RELEASE, 16'h0000, pick_gap(), 1'b0, 1'b0);
        queue_req(FUNC_ALLOC,   16'h0000, pick_gap(), 1'b0, 1'b0);
        queue_req(FUNC_RELEASE, 16'hAAAA, pick_gap(), 1'b0, 1'b0);
        queue_req(FUNC_RELEASE, 16'h5555, pick_gap(), 1'b0, 1'b0);
        queue_req(FUNC_RELEASE, 16'h8000, pick_gap(), 1'b0, 1'b0);
        queue_req(FUNC_RELEASE, 16'h7FFF, pick_gap(), 1'b0, 1'b0);
        queue_req(FUNC_RELEASE, 16'h003F, pick_gap(), 1'b0, 1'b0);
        queue_req(FUNC_RELEASE, 16'h0040, pick_gap(), 1'b0, 1'b0);
        queue_req(FUNC_RELEASE, 16'h0002, pick_gap(), 1'b0, 1'b0);
        queue_req(FUNC_ALLOC,   16'h1234, pick_gap(), 1'b0, 1'b0);
        queue_req(FUNC_ALLOC,   16'hFEDC, pick_gap(), 1'b0, 1'b0);

        outstanding = 3;
        for (n = 0; n < 1850; n++) begin
            r     = $urandom_range(0, 99);
            quiet = (n >= 1500 && n < 1600);
            if (r < 58) begin
                queue_req(FUNC_ALLOC, HANDLE_W'($urandom), quiet ? 8'd0 : pick_gap(),
                          n == 900, quiet);
                outstanding++;
            end else if (r < 90) begin
                queue_req(FUNC_RELEASE, HANDLE_W'($urandom_range(0, outstanding + 8)),
                          quiet ? 8'd0 : pick_gap(), n == 900, quiet);
                if (outstanding > 0) outstanding--;
            end else begin
                queue_req(FUNC_RELEASE, HANDLE_W'($urandom), quiet ? 8'd0 : pick_gap(),
                          n == 900, quiet);
            end
        end

        // Recycle a few handles at both ends and in the middle of the map.
        queue_req(FUNC_RELEASE, 16'hFFFF, 8'd0, 1'b0, 1'b1);
        queue_req(FUNC_RELEASE, 16'h0000, 8'd0, 1'b0, 1'b1);
        queue_req(FUNC_RELEASE, 16'd12345, 8'd0, 1'b0, 1'b1);
        queue_req(FUNC_RELEASE, 16'h0000, 8'd0, 1'b0, 1'b1);
        for (n = 0; n < 4; n++)
            queue_req(FUNC_ALLOC, HANDLE_W'($urandom), pick_gap(), 1'b0, 1'b0);
        queue_req(FUNC_RELEASE, 16'hFFFF, pick_gap(), 1'b0, 1'b0);
        queue_req(FUNC_ALLOC,   16'h0000, pick_gap(), 1'b0, 1'b0);
        queue_req(FUNC_ALLOC,   16'hFFFF, pick_gap(), 1'b0, 1'b0);

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_reqs.size() > 0 || s_axis_tvalid) @(posedge i_clk);
        while (due_replies.size() > 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);

        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
src/bha_pkg.sv
src/bha_lowest_set.sv
src/bitmap_handle_allocator_core.sv
bench/tb_top.sv
